// ===== src/bbr_pkg.sv =====
// Package for the breadth-first renumbering unit.
// Holds the request and result structs and the status and command codes.
`timescale 1ns / 1ps
package bbr_pkg;

  localparam int NB_W = 10;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NOTHING = 2'd3
  } bbr_status_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } bbr_kind_t;

  typedef struct packed {
    logic            func;
    logic [NB_W-1:0] neighbour;
    logic            has_neighbour;
    logic            end_of_cell;
    logic            end_of_graph;
  } bbr_in_t;

  typedef struct packed {
    logic [NB_W-1:0] new_cell;
    logic            is_last;
    logic [1:0]      status;
  } bbr_out_t;

  typedef struct packed {
    bbr_kind_t       kind;
    logic [NB_W-1:0] neighbour;
    logic            has_neighbour;
    logic            close_cell;
    logic            end_of_graph;
  } bbr_cmd_t;

endpackage

// ===== src/bbr_front.sv =====
// Front end: accepts input requests, classifies them into commands and
// holds them in a two-entry queue for the back end. Depends on bbr_pkg.
`timescale 1ns / 1ps
module bbr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bbr_pkg::bbr_in_t in_data,
  output logic             cmd_valid,
  output bbr_pkg::bbr_cmd_t cmd,
  input  logic             cmd_pop
);
  import bbr_pkg::*;

  bbr_cmd_t   q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       push;
  bbr_cmd_t   cls;

  always_comb begin
    cls.kind          = in_data.func ? CMD_READ : CMD_LOAD;
    cls.neighbour     = in_data.neighbour;
    cls.has_neighbour = in_data.has_neighbour;
    cls.close_cell    = in_data.end_of_cell | in_data.end_of_graph;
    cls.end_of_graph  = in_data.end_of_graph;
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    wr_nxt  = wr_r;
    if (push) begin
      wr_nxt = ~wr_r;
    end
    if (cmd_pop && cmd_valid) begin
      rd_nxt = ~rd_r;
    end
    case ({push, cmd_pop && cmd_valid})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= cls;
    end
  end

endmodule

// ===== src/bbr_back.sv =====
// Back end: adjacency store, visited bits, walk queue and order list,
// the walk sequencer and the result register. Depends on bbr_pkg.
`timescale 1ns / 1ps
module bbr_back #(
  parameter int MAX_CELLS   = 1024,
  parameter int MAX_ENTRIES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  bbr_pkg::bbr_cmd_t  cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output bbr_pkg::bbr_out_t  out_data
);
  import bbr_pkg::*;

  localparam int CNT_W = $clog2(MAX_CELLS + 1);
  localparam int CIW   = $clog2(MAX_CELLS);
  localparam int ENT_W = $clog2(MAX_ENTRIES + 1);
  localparam int EIW   = $clog2(MAX_ENTRIES);
  localparam int QD    = MAX_CELLS + MAX_ENTRIES;
  localparam int QW    = $clog2(QD + 1);
  localparam int QIW   = $clog2(QD);
  localparam int CMP_W = (CNT_W > NB_W) ? CNT_W : NB_W;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_CLR     = 14'b00000000000010,
    S_SEED    = 14'b00000000000100,
    S_SEEDCHK = 14'b00000000001000,
    S_POP     = 14'b00000000010000,
    S_POPW    = 14'b00000000100000,
    S_POPCHK  = 14'b00000001000000,
    S_HI_W    = 14'b00000010000000,
    S_LO_W    = 14'b00000100000000,
    S_NREAD   = 14'b00001000000000,
    S_NCHK    = 14'b00010000000000,
    S_NVIS    = 14'b00100000000000,
    S_DONE    = 14'b01000000000000,
    S_RDW     = 14'b10000000000000
  } bbr_state_t;

  bbr_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cc_r, cc_nxt, rp_r, rp_nxt, clr_r, clr_nxt, c_r, c_nxt;
  logic [CNT_W-1:0] placed_r, placed_nxt;
  logic [ENT_W-1:0] ec_r, ec_nxt, e_r, e_nxt, hi_r, hi_nxt;
  logic [QW-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [NB_W-1:0]  nbmax_r, nbmax_nxt;
  logic             any_r, any_nxt, ready_r, ready_nxt;
  logic             full_r, full_nxt, bad_r, bad_nxt;
  logic [CIW-1:0]   x_r, x_nxt, n_r, n_nxt;
  logic             out_valid_r, out_valid_nxt;
  bbr_out_t         out_r, out_nxt;

  logic              vis_mem [MAX_CELLS];
  logic              vis_we, vis_wd, vis_q;
  logic [CIW-1:0]    vis_wa, vis_ra;
  logic [CIW-1:0]    q_mem [QD];
  logic              q_we;
  logic [QIW-1:0]    q_wa, q_ra;
  logic [CIW-1:0]    q_wd, q_q;
  logic [ENT_W-1:0]  cs_mem [MAX_CELLS];
  logic              cs_we;
  logic [CIW-1:0]    cs_wa, cs_ra;
  logic [ENT_W-1:0]  cs_wd, cs_q;
  logic [NB_W-1:0]   ns_mem [MAX_ENTRIES];
  logic              ns_we;
  logic [EIW-1:0]    ns_wa, ns_ra;
  logic [NB_W-1:0]   ns_wd, ns_q;
  logic [NB_W-1:0]   ord_mem [MAX_CELLS];
  logic              ord_we;
  logic [CIW-1:0]    ord_wa, ord_ra;
  logic [NB_W-1:0]   ord_wd, ord_q;

  logic             out_free;
  logic [CNT_W-1:0] cc_e;
  logic [ENT_W-1:0] ec_e;
  logic [NB_W-1:0]  nbmax_e;
  logic             any_e, full_c;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt  = state_r;
    cc_nxt     = cc_r;
    rp_nxt     = rp_r;
    clr_nxt    = clr_r;
    c_nxt      = c_r;
    placed_nxt = placed_r;
    ec_nxt     = ec_r;
    e_nxt      = e_r;
    hi_nxt     = hi_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    nbmax_nxt  = nbmax_r;
    any_nxt    = any_r;
    ready_nxt  = ready_r;
    full_nxt   = full_r;
    bad_nxt    = bad_r;
    x_nxt      = x_r;
    n_nxt      = n_r;
    cmd_pop    = 1'b0;
    out_nxt    = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    vis_we = 1'b0; vis_wa = '0; vis_wd = 1'b0; vis_ra = '0;
    q_we   = 1'b0; q_wa   = '0; q_wd   = '0;   q_ra   = '0;
    cs_we  = 1'b0; cs_wa  = '0; cs_wd  = '0;   cs_ra  = '0;
    ns_we  = 1'b0; ns_wa  = '0; ns_wd  = '0;   ns_ra  = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0;   ord_ra = '0;
    cc_e    = ready_r ? '0 : cc_r;
    ec_e    = ready_r ? '0 : ec_r;
    nbmax_e = ready_r ? '0 : nbmax_r;
    any_e   = ready_r ? 1'b0 : any_r;
    full_c  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_READ) begin
            if (!ready_r || rp_r >= cc_r) begin
              out_valid_nxt   = 1'b1;
              out_nxt.new_cell = '0;
              out_nxt.is_last  = 1'b0;
              out_nxt.status   = ST_NOTHING;
            end else begin
              ord_ra    = CIW'(rp_r);
              state_nxt = S_RDW;
            end
          end else begin
            ready_nxt = 1'b0;
            rp_nxt    = '0;
            cc_nxt    = cc_e;
            ec_nxt    = ec_e;
            nbmax_nxt = nbmax_e;
            any_nxt   = any_e;
            if (cc_e >= CNT_W'(MAX_CELLS)) begin
              full_c = 1'b1;
            end else begin
              if (cmd.has_neighbour) begin
                if (ec_e >= ENT_W'(MAX_ENTRIES)) begin
                  full_c = 1'b1;
                end else begin
                  ns_we  = 1'b1;
                  ns_wa  = EIW'(ec_e);
                  ns_wd  = cmd.neighbour;
                  ec_nxt = ec_e + 1'b1;
                  any_nxt = 1'b1;
                  if (cmd.neighbour > nbmax_e) begin
                    nbmax_nxt = cmd.neighbour;
                  end
                end
              end
              if (cmd.close_cell) begin
                cs_we  = 1'b1;
                cs_wa  = CIW'(cc_e);
                cs_wd  = ec_nxt;
                cc_nxt = cc_e + 1'b1;
              end
            end
            if (cmd.end_of_graph) begin
              full_nxt   = full_c;
              bad_nxt    = any_nxt && (CMP_W'(nbmax_nxt) >= CMP_W'(cc_nxt));
              clr_nxt    = '0;
              head_nxt   = '0;
              tail_nxt   = '0;
              placed_nxt = '0;
              state_nxt  = S_CLR;
            end else if (full_c) begin
              out_valid_nxt    = 1'b1;
              out_nxt.new_cell = '0;
              out_nxt.is_last  = 1'b0;
              out_nxt.status   = ST_FULL;
            end
          end
        end
      end
      S_CLR: begin
        vis_we = 1'b1;
        vis_wa = CIW'(clr_r);
        vis_wd = 1'b0;
        if (clr_r + 1'b1 == cc_r) begin
          c_nxt     = '0;
          state_nxt = S_SEED;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_SEED: begin
        if (c_r == cc_r) begin
          state_nxt = S_DONE;
        end else begin
          vis_ra    = CIW'(c_r);
          state_nxt = S_SEEDCHK;
        end
      end
      S_SEEDCHK: begin
        if (vis_q) begin
          c_nxt     = c_r + 1'b1;
          state_nxt = S_SEED;
        end else begin
          if (tail_r < QW'(QD)) begin
            q_we     = 1'b1;
            q_wa     = QIW'(tail_r);
            q_wd     = CIW'(c_r);
            tail_nxt = tail_r + 1'b1;
          end
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (head_r == tail_r) begin
          c_nxt     = c_r + 1'b1;
          state_nxt = S_SEED;
        end else begin
          q_ra      = QIW'(head_r);
          head_nxt  = head_r + 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        x_nxt     = q_q;
        vis_ra    = q_q;
        state_nxt = S_POPCHK;
      end
      S_POPCHK: begin
        if (vis_q) begin
          state_nxt = S_POP;
        end else begin
          vis_we     = 1'b1;
          vis_wa     = x_r;
          vis_wd     = 1'b1;
          ord_we     = 1'b1;
          ord_wa     = CIW'(placed_r);
          ord_wd     = NB_W'(x_r);
          placed_nxt = placed_r + 1'b1;
          cs_ra      = x_r;
          state_nxt  = S_HI_W;
        end
      end
      S_HI_W: begin
        hi_nxt = cs_q;
        if (x_r == '0) begin
          e_nxt     = '0;
          state_nxt = S_NREAD;
        end else begin
          cs_ra     = x_r - 1'b1;
          state_nxt = S_LO_W;
        end
      end
      S_LO_W: begin
        e_nxt     = cs_q;
        state_nxt = S_NREAD;
      end
      S_NREAD: begin
        if (e_r >= hi_r || e_r >= ENT_W'(MAX_ENTRIES)) begin
          state_nxt = S_POP;
        end else begin
          ns_ra     = EIW'(e_r);
          e_nxt     = e_r + 1'b1;
          state_nxt = S_NCHK;
        end
      end
      S_NCHK: begin
        if (CMP_W'(ns_q) < CMP_W'(cc_r)) begin
          n_nxt     = CIW'(CMP_W'(ns_q));
          vis_ra    = CIW'(CMP_W'(ns_q));
          state_nxt = S_NVIS;
        end else begin
          state_nxt = S_NREAD;
        end
      end
      S_NVIS: begin
        if (!vis_q && tail_r < QW'(QD)) begin
          q_we     = 1'b1;
          q_wa     = QIW'(tail_r);
          q_wd     = n_r;
          tail_nxt = tail_r + 1'b1;
        end
        state_nxt = S_NREAD;
      end
      S_DONE: begin
        out_valid_nxt    = 1'b1;
        out_nxt.new_cell = '0;
        out_nxt.is_last  = 1'b0;
        out_nxt.status   = full_r ? ST_FULL : (bad_r ? ST_RANGE : ST_OK);
        ready_nxt        = 1'b1;
        rp_nxt           = '0;
        state_nxt        = S_IDLE;
      end
      S_RDW: begin
        out_valid_nxt    = 1'b1;
        out_nxt.new_cell = ord_q;
        out_nxt.is_last  = (rp_r + 1'b1 == cc_r);
        out_nxt.status   = ST_OK;
        rp_nxt           = rp_r + 1'b1;
        state_nxt        = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cc_r        <= '0;
      ec_r        <= '0;
      rp_r        <= '0;
      ready_r     <= 1'b0;
      nbmax_r     <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cc_r        <= cc_nxt;
      ec_r        <= ec_nxt;
      rp_r        <= rp_nxt;
      ready_r     <= ready_nxt;
      nbmax_r     <= nbmax_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_r    <= clr_nxt;
    c_r      <= c_nxt;
    placed_r <= placed_nxt;
    e_r      <= e_nxt;
    hi_r     <= hi_nxt;
    head_r   <= head_nxt;
    tail_r   <= tail_nxt;
    full_r   <= full_nxt;
    bad_r    <= bad_nxt;
    x_r      <= x_nxt;
    n_r      <= n_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    q_q <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem[cs_wa] <= cs_wd;
    end
    cs_q <= cs_mem[cs_ra];
  end

  always_ff @(posedge clk) begin
    if (ns_we) begin
      ns_mem[ns_wa] <= ns_wd;
    end
    ns_q <= ns_mem[ns_ra];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    ord_q <= ord_mem[ord_ra];
  end

endmodule

// ===== src/bfs_bandwidth_renumbering_unit.sv =====
// Breadth-first renumbering unit: a load's result, if any, passes front queue and
// output register, a read's also the order store; one load per cycle unless the
// output stalls; reads do not overlap. End of graph: visited bits are cleared,
// then each cell, stored neighbour and repeated queue entry is walked before the
// status result. Results leave through one output register. Reset is synchronous
// and clears the queue, counters and graph_ready; the stores are written before use.
`timescale 1ns / 1ps
module bfs_bandwidth_renumbering_unit #(
  parameter int MAX_CELLS   = 1024,
  parameter int MAX_ENTRIES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bbr_pkg::bbr_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bbr_pkg::bbr_out_t  out_data
);
  import bbr_pkg::*;

  logic     cmd_valid, cmd_pop;
  bbr_cmd_t cmd;

  bbr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  bbr_back #(
    .MAX_CELLS   (MAX_CELLS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
